[src/csd_pkg.sv]
// Shared types and constants for the chunk stream demultiplexer.
package csd_pkg;

  localparam int HDR_BYTES = 8;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;

  localparam logic [31:0] CODE_LIST = 32'h4C49_5354;
  localparam logic [31:0] CODE_IFRM = 32'h6966_726D;
  localparam logic [31:0] CODE_PFRM = 32'h7066_726D;
  localparam logic [31:0] CODE_CFRM = 32'h6366_726D;
  localparam logic [31:0] CODE_SND  = 32'h736E_645F;

  typedef enum logic [2:0] {
    REG_SECTION_LENGTH = 3'd0,
    REG_TIMESTAMP_STEP = 3'd1,
    REG_START_IS_ODD   = 3'd2,
    REG_VIDEO_ENABLE   = 3'd3,
    REG_AUDIO_MASK     = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_DATA        = 3'd0,
    ST_EMPTY_AUDIO = 3'd1,
    ST_END         = 3'd2,
    ST_UNKNOWN     = 3'd3,
    ST_BAD_SIZE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_BOUNDARY   = 3'd0,
    PH_HEADER     = 3'd1,
    PH_SKIP       = 3'd2,
    PH_VIDEO      = 3'd3,
    PH_AUDIO_ID   = 3'd4,
    PH_AUDIO_SKIP = 3'd5,
    PH_AUDIO      = 3'd6,
    PH_HALT       = 3'd7
  } phase_t;

  typedef struct packed {
    logic [31:0] section_length;
    logic [19:0] timestamp_step;
    logic        start_is_odd;
    logic        video_enable;
    logic [7:0]  audio_enable_mask;
  } cfg_t;

  // One queued job: a single beat, or the eight header bytes replayed as a burst
  typedef struct packed {
    logic        burst;
    logic [63:0] data;
    logic        stream_kind;
    logic [2:0]  audio_number;
    logic [47:0] time_stamp;
    logic        first;
    logic        last;
    status_t     status;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        stream_kind;
    logic [2:0]  audio_number;
    logic [47:0] time_stamp;
    logic        first;
    logic        last;
    status_t     status;
  } beat_t;

endpackage

[src/csd_front.sv]
// Front end: byte parser, chunk header matching and job generation.
module csd_front import csd_pkg::*; #(
  parameter int AUDIO_STREAMS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  input  logic [7:0] in_data_byte,
  output logic       in_ready,
  input  logic       q_full,
  output logic       q_push,
  output cmd_t       q_cmd
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  hdr_r [HDR_BYTES];
  logic [7:0]  hdr_w [HDR_BYTES];
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [47:0] vtime_r, vtime_nxt;
  logic [2:0]  cur_audio_r, cur_audio_nxt;
  logic        keep_r, keep_nxt;
  logic        hdr_we;
  logic [2:0]  wr_idx;
  logic        acc;
  logic [31:0] pos_inc, code, size, audio_id;
  logic [63:0] hdr_flat;
  logic        left_last;

  assign in_ready  = !q_full;
  assign acc       = in_valid && in_ready;
  assign pos_inc   = pos_r + 32'd1;
  assign left_last = (left_r <= 32'd1);

  always_comb begin
    case (phase_r)
      PH_HEADER:   wr_idx = cnt_r[2:0];
      PH_AUDIO_ID: wr_idx = {1'b0, cnt_r[1:0]};
      default:     wr_idx = 3'd0;
    endcase
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_w[i] = hdr_r[i];
    end
    hdr_w[wr_idx] = in_data_byte;
    for (int i = 0; i < HDR_BYTES; i++) begin
      hdr_flat[8*i +: 8] = hdr_w[i];
    end
  end

  assign code     = {hdr_w[0], hdr_w[1], hdr_w[2], hdr_w[3]};
  assign size     = {hdr_w[7], hdr_w[6], hdr_w[5], hdr_w[4]};
  assign audio_id = {hdr_w[3], hdr_w[2], hdr_w[1], hdr_w[0]};

  always_comb begin
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    pos_nxt       = pos_r;
    vtime_nxt     = vtime_r;
    cur_audio_nxt = cur_audio_r;
    keep_nxt      = keep_r;
    hdr_we        = 1'b0;
    q_push        = 1'b0;
    q_cmd         = '0;
    q_cmd.status  = ST_DATA;
    if (acc) begin
      case (phase_r)
        PH_BOUNDARY: begin
          if (pos_r[0] ^ cfg.start_is_odd) begin
            // pad byte
            pos_nxt = pos_inc;
            if (pos_inc >= cfg.section_length) begin
              q_push       = 1'b1;
              q_cmd.status = ST_END;
              phase_nxt    = PH_HALT;
            end
          end else if (pos_r >= cfg.section_length) begin
            q_push       = 1'b1;
            q_cmd.status = ST_END;
            phase_nxt    = PH_HALT;
          end else begin
            hdr_we    = 1'b1;
            cnt_nxt   = 4'd1;
            pos_nxt   = pos_inc;
            phase_nxt = PH_HEADER;
          end
        end
        PH_HEADER: begin
          hdr_we  = 1'b1;
          cnt_nxt = cnt_r + 4'd1;
          pos_nxt = pos_inc;
          if (cnt_r == 4'(HDR_BYTES - 1)) begin
            if (code == CODE_LIST) begin
              vtime_nxt = vtime_r + {28'd0, cfg.timestamp_step};
              left_nxt  = 32'd4;
              phase_nxt = PH_SKIP;
            end else if (code == CODE_IFRM || code == CODE_PFRM || code == CODE_CFRM) begin
              keep_nxt = cfg.video_enable;
              if (cfg.video_enable) begin
                q_push           = 1'b1;
                q_cmd.burst      = 1'b1;
                q_cmd.data       = hdr_flat;
                q_cmd.time_stamp = vtime_r;
                q_cmd.first      = 1'b1;
                q_cmd.last       = (size == 32'd0);
              end
              left_nxt  = size;
              phase_nxt = (size != 32'd0) ? PH_VIDEO : PH_BOUNDARY;
            end else if (code == CODE_SND) begin
              if (size < 32'd8) begin
                q_push       = 1'b1;
                q_cmd.status = ST_BAD_SIZE;
                phase_nxt    = PH_HALT;
              end else begin
                left_nxt  = size - 32'd8;
                cnt_nxt   = 4'd0;
                phase_nxt = PH_AUDIO_ID;
              end
            end else begin
              q_push       = 1'b1;
              q_cmd.status = ST_UNKNOWN;
              phase_nxt    = PH_HALT;
            end
          end
        end
        PH_SKIP: begin
          pos_nxt = pos_inc;
          if (left_last) begin
            left_nxt  = 32'd0;
            phase_nxt = PH_BOUNDARY;
          end else begin
            left_nxt = left_r - 32'd1;
          end
        end
        PH_VIDEO: begin
          pos_nxt = pos_inc;
          if (keep_r) begin
            q_push           = 1'b1;
            q_cmd.data       = {56'd0, in_data_byte};
            q_cmd.time_stamp = vtime_r;
            q_cmd.last       = left_last;
          end
          if (left_last) begin
            left_nxt  = 32'd0;
            phase_nxt = PH_BOUNDARY;
          end else begin
            left_nxt = left_r - 32'd1;
          end
        end
        PH_AUDIO_ID: begin
          hdr_we  = 1'b1;
          cnt_nxt = cnt_r + 4'd1;
          pos_nxt = pos_inc;
          if (cnt_r == 4'd3) begin
            keep_nxt = (audio_id < 32'(AUDIO_STREAMS)) && (audio_id < 32'd8) &&
                       cfg.audio_enable_mask[audio_id[2:0]];
            cur_audio_nxt = audio_id[2:0];
            cnt_nxt       = 4'd0;
            phase_nxt     = PH_AUDIO_SKIP;
          end
        end
        PH_AUDIO_SKIP: begin
          cnt_nxt = cnt_r + 4'd1;
          pos_nxt = pos_inc;
          if (cnt_r == 4'd3) begin
            cnt_nxt = 4'd0;
            if (left_r == 32'd0) begin
              if (keep_r) begin
                q_push             = 1'b1;
                q_cmd.stream_kind  = 1'b1;
                q_cmd.audio_number = cur_audio_r;
                q_cmd.first        = 1'b1;
                q_cmd.last         = 1'b1;
                q_cmd.status       = ST_EMPTY_AUDIO;
              end
              phase_nxt = PH_BOUNDARY;
            end else begin
              phase_nxt = PH_AUDIO;
            end
          end
        end
        PH_AUDIO: begin
          pos_nxt = pos_inc;
          if (keep_r) begin
            q_push             = 1'b1;
            q_cmd.data         = {56'd0, in_data_byte};
            q_cmd.stream_kind  = 1'b1;
            q_cmd.audio_number = cur_audio_r;
            q_cmd.first        = (cnt_r == 4'd0);
            q_cmd.last         = left_last;
          end
          cnt_nxt = 4'd1;
          if (left_last) begin
            left_nxt  = 32'd0;
            phase_nxt = PH_BOUNDARY;
          end else begin
            left_nxt = left_r - 32'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_BOUNDARY;
      cnt_r       <= 4'd0;
      left_r      <= 32'd0;
      pos_r       <= 32'd0;
      vtime_r     <= 48'd0;
      cur_audio_r <= 3'd0;
      keep_r      <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
      pos_r       <= pos_nxt;
      vtime_r     <= vtime_nxt;
      cur_audio_r <= cur_audio_nxt;
      keep_r      <= keep_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_r[wr_idx] <= in_data_byte;
    end
  end

endmodule

[src/csd_queue.sv]
// Small job queue between parser and output sequencer.
module csd_queue import csd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd,
  input  logic pop
);

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full       = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_ptr_r];

  // depth is a power of two, pointers wrap on their own
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[src/csd_back.sv]
// Back end: expands queued jobs into output beats behind an output register.
module csd_back import csd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  head_valid,
  input  cmd_t  head_cmd,
  output logic  pop,
  output logic  out_valid,
  input  logic  out_ready,
  output beat_t out_beat
);

  localparam logic [2:0] BURST_LAST = 3'(HDR_BYTES - 1);

  logic [2:0] idx_r, idx_nxt;
  beat_t      out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       load;
  beat_t      beat;

  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && (!head_cmd.burst || idx_r == BURST_LAST);

  always_comb begin
    beat.stream_kind  = head_cmd.stream_kind;
    beat.audio_number = head_cmd.audio_number;
    beat.time_stamp   = head_cmd.time_stamp;
    beat.status       = head_cmd.status;
    if (head_cmd.burst) begin
      beat.out_byte = head_cmd.data[8*idx_r +: 8];
      beat.first    = (idx_r == 3'd0);
      beat.last     = (idx_r == BURST_LAST) && head_cmd.last;
    end else begin
      beat.out_byte = head_cmd.data[7:0];
      beat.first    = head_cmd.first;
      beat.last     = head_cmd.last;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    idx_nxt       = idx_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      out_valid_nxt = 1'b1;
      out_nxt       = beat;
      idx_nxt       = (head_cmd.burst && idx_r != BURST_LAST) ? idx_r + 3'd1 : 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_r;

endmodule

[src/chunk_stream_demuxer_unit.sv]
// Top level of the chunk stream demultiplexer: config registers, parser, queue, output.
// Throughput: one input byte per cycle while in_ready is high; a kept video chunk header replays
//   as eight beats, and with payload jobs behind it the four-entry queue fills and in_ready drops.
// Output path: a result beat is registered in the queue, then in the output register, and is
//   held back further while earlier beats are still waiting.
// Reset: synchronous, active low; clears parser, queue and output valid; loads register defaults.
module chunk_stream_demuxer_unit import csd_pkg::*; #(
  parameter int AUDIO_STREAMS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // input beats
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  // result beats
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_stream_kind,
  output logic [2:0]  out_audio_number,
  output logic [47:0] out_time_stamp,
  output logic        out_first_of_packet,
  output logic        out_last_of_packet,
  output logic [2:0]  out_status
);

  cfg_t  cfg_r;
  logic  q_push, q_full, q_head_valid, q_pop;
  cmd_t  q_push_cmd, q_head_cmd;
  beat_t beat;

  // Register file. Write only while idle (the block itself does not enforce this), so no shadowing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.section_length    <= 32'd0;
      cfg_r.timestamp_step    <= 20'd40000;
      cfg_r.start_is_odd      <= 1'b0;
      cfg_r.video_enable      <= 1'b1;
      cfg_r.audio_enable_mask <= 8'd0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_SECTION_LENGTH: cfg_r.section_length    <= cfg_wdata;
        REG_TIMESTAMP_STEP: cfg_r.timestamp_step    <= cfg_wdata[19:0];
        REG_START_IS_ODD:   cfg_r.start_is_odd      <= cfg_wdata[0];
        REG_VIDEO_ENABLE:   cfg_r.video_enable      <= cfg_wdata[0];
        REG_AUDIO_MASK:     cfg_r.audio_enable_mask <= cfg_wdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Parser: one byte per beat, at most one job per byte
  csd_front #(
    .AUDIO_STREAMS(AUDIO_STREAMS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_ready     (in_ready),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_push_cmd)
  );

  // Decouples parser from output stalls and header bursts
  csd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop)
  );

  // Output sequencer: burst jobs pop only as their eighth beat loads
  csd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_cmd   (q_head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_beat   (beat)
  );

  assign out_byte            = beat.out_byte;
  assign out_stream_kind     = beat.stream_kind;
  assign out_audio_number    = beat.audio_number;
  assign out_time_stamp      = beat.time_stamp;
  assign out_first_of_packet = beat.first;
  assign out_last_of_packet  = beat.last;
  assign out_status          = beat.status;

endmodule

[src/csd_checker.sv]
// Port-level checks for the chunk stream demultiplexer, bound to the top level.
module csd_checker import csd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_stream_kind,
  input logic [2:0]  out_audio_number,
  input logic [47:0] out_time_stamp,
  input logic        out_first_of_packet,
  input logic        out_last_of_packet,
  input logic [2:0]  out_status
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_status)
      && $stable(out_last_of_packet) && $stable(out_audio_number))
    else $error("output beat changed while stalled");

  // non-data beats: both packet marks set only for an empty audio packet
  a_marks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DATA |->
      out_first_of_packet == out_last_of_packet &&
      out_first_of_packet == (out_status == ST_EMPTY_AUDIO))
    else $error("packet marks wrong on status beat");

  // a halting beat is the last thing ever delivered
  a_halt_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready &&
    (out_status == ST_END || out_status == ST_UNKNOWN || out_status == ST_BAD_SIZE)
    |=> !out_valid)
    else $error("beat delivered after halt");

  // audio beats carry no timestamp
  a_audio_ts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_kind |-> out_time_stamp == 48'd0)
    else $error("audio beat with timestamp");

endmodule

bind chunk_stream_demuxer_unit csd_checker u_csd_checker (.*);
